@@ hdl/hdlc_pkg.sv @@
package hdlc_pkg;

  localparam int unsigned MaxFrame = 2048;
  localparam int unsigned LenW     = 12;
  localparam int unsigned TailLen  = 4;

  localparam logic [7:0]  FlagCode = 8'h7E;
  localparam logic [7:0]  EscCode  = 8'h7D;
  localparam logic [7:0]  EscFlip  = 8'h20;
  localparam logic [31:0] CrcInit  = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly  = 32'hEDB8_8320;

  localparam logic KindData = 1'b0;
  localparam logic KindEnd  = 1'b1;

  localparam logic [2:0] StatusGood    = 3'd0;
  localparam logic [2:0] StatusCrcBad  = 3'd1;
  localparam logic [2:0] StatusShort   = 3'd2;
  localparam logic [2:0] StatusAbort   = 3'd3;
  localparam logic [2:0] StatusOverrun = 3'd4;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [7:0]  data;
    logic [2:0]  status;
    logic [31:0] err_total;
  } result_t;

  // Reflected CRC-32, one byte; flattens to an XOR network.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/hdlc_core.sv @@
module hdlc_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             byte_i,
  output hdlc_pkg::result_t      res_o
);

  logic                          esc_q, esc_d;
  logic [hdlc_pkg::LenW-1:0]     len_q, len_d;
  logic [7:0]                    win_q [hdlc_pkg::TailLen];
  logic [7:0]                    win_d [hdlc_pkg::TailLen];
  logic [31:0]                   crc_q, crc_d;
  logic [31:0]                   cnt_q, cnt_d;

  logic [7:0]  data_byte;
  logic [31:0] rx_crc;
  logic        len_full;
  logic        len_short;

  assign data_byte = esc_q ? (byte_i ^ hdlc_pkg::EscFlip) : byte_i;
  assign rx_crc    = {win_q[3], win_q[2], win_q[1], win_q[0]};
  assign len_full  = {1'b0, len_q} >= (hdlc_pkg::LenW + 1)'(hdlc_pkg::MaxFrame - 1);
  assign len_short = len_q <= hdlc_pkg::LenW'(hdlc_pkg::TailLen);

  always_comb begin
    esc_d = esc_q;
    len_d = len_q;
    crc_d = crc_q;
    cnt_d = cnt_q;
    for (int i = 0; i < hdlc_pkg::TailLen; i++) begin
      win_d[i] = win_q[i];
    end
    res_o.valid  = 1'b0;
    res_o.kind   = hdlc_pkg::KindEnd;
    res_o.data   = 8'd0;
    res_o.status = hdlc_pkg::StatusGood;

    if (byte_i == hdlc_pkg::FlagCode) begin
      esc_d = 1'b0;
      len_d = '0;
      crc_d = hdlc_pkg::CrcInit;
      for (int i = 0; i < hdlc_pkg::TailLen; i++) begin
        win_d[i] = 8'd0;
      end
      if (esc_q) begin
        res_o.valid  = 1'b1;
        res_o.status = hdlc_pkg::StatusAbort;
      end else if (len_q == '0) begin
        res_o.valid = 1'b0;
      end else if (len_short) begin
        res_o.valid  = 1'b1;
        res_o.status = hdlc_pkg::StatusShort;
      end else begin
        res_o.valid = 1'b1;
        if ((crc_q ^ hdlc_pkg::CrcInit) != rx_crc) begin
          res_o.status = hdlc_pkg::StatusCrcBad;
          cnt_d        = cnt_q + 32'd1;
        end
      end
    end else if (byte_i == hdlc_pkg::EscCode) begin
      if (esc_q) begin
        // double escape aborts; escape stays pending
        len_d = '0;
        crc_d = hdlc_pkg::CrcInit;
        for (int i = 0; i < hdlc_pkg::TailLen; i++) begin
          win_d[i] = 8'd0;
        end
        res_o.valid  = 1'b1;
        res_o.status = hdlc_pkg::StatusAbort;
      end else begin
        esc_d = 1'b1;
      end
    end else begin
      esc_d = 1'b0;
      if (len_full) begin
        // drop the byte and start a new frame without a flag
        len_d = '0;
        crc_d = hdlc_pkg::CrcInit;
        for (int i = 0; i < hdlc_pkg::TailLen; i++) begin
          win_d[i] = 8'd0;
        end
        res_o.valid  = 1'b1;
        res_o.status = hdlc_pkg::StatusOverrun;
      end else begin
        for (int i = 0; i < hdlc_pkg::TailLen - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[hdlc_pkg::TailLen-1] = data_byte;
        len_d = len_q + hdlc_pkg::LenW'(1);
        if (len_q >= hdlc_pkg::LenW'(hdlc_pkg::TailLen)) begin
          crc_d        = hdlc_pkg::crc32_byte(crc_q, win_q[0]);
          res_o.valid  = 1'b1;
          res_o.kind   = hdlc_pkg::KindData;
          res_o.data   = win_q[0];
        end
      end
    end
    res_o.err_total = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
      len_q <= '0;
      crc_q <= hdlc_pkg::CrcInit;
      cnt_q <= 32'd0;
      for (int i = 0; i < hdlc_pkg::TailLen; i++) begin
        win_q[i] <= 8'd0;
      end
    end else if (step_i) begin
      esc_q <= esc_d;
      len_q <= len_d;
      crc_q <= crc_d;
      cnt_q <= cnt_d;
      for (int i = 0; i < hdlc_pkg::TailLen; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

endmodule

@@ hdl/hdlc_crc32_deframer.sv @@
// HDLC deframer with CRC-32 check. One raw line byte per beat in; payload bytes come out
// four bytes late so the trailing CRC is never shown, and each frame ends with one end
// marker carrying its status (good, CRC mismatch, too short, aborted, overflow) and the
// running mismatch count. The payload is streamed, so discard a frame on a bad status.
// Throughput is one byte per cycle while out_stall_i is low, set by the bytewise CRC XOR
// network. Bytes pass an input then a result register. No clearing pass at reset.
module hdlc_crc32_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  frame_status_o,
  output logic [31:0] crc_error_total_o
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q;
  logic              advance;
  logic              step;
  hdlc_pkg::result_t res;
  hdlc_pkg::result_t res_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  hdlc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res.valid;
    end
  end

  // hold the result beat while stalled
  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = res_q.kind;
  assign out_byte_o        = res_q.data;
  assign frame_status_o    = res_q.status;
  assign crc_error_total_o = res_q.err_total;

endmodule

@@ hdl/hdlc_checker.sv @@
module hdlc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  in_byte_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        kind_o,
  input logic [7:0]  out_byte_o,
  input logic [2:0]  frame_status_o,
  input logic [31:0] crc_error_total_o
);

  logic unused_in;
  assign unused_in = in_valid_i ^ in_stall_o ^ (^in_byte_i);

  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(kind_o))
    else $error("result beat changed while stalled");

  ap_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == hdlc_pkg::KindEnd |-> out_byte_o == 8'd0)
    else $error("end marker carries a nonzero byte");

  ap_data_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == hdlc_pkg::KindData |-> frame_status_o == hdlc_pkg::StatusGood)
    else $error("payload beat carries a status");

  ap_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_status_o <= hdlc_pkg::StatusOverrun)
    else $error("status code out of range");

endmodule

bind hdlc_crc32_deframer hdlc_checker u_hdlc_checker (.*);

@@ dv/hdlc_crc32_deframer_checker.sv @@
`timescale 1ns / 1ps
module hdlc_crc32_deframer_checker
  import hdlc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        kind_i,
  input  logic [7:0]  out_byte_i,
  input  logic [2:0]  frame_status_i,
  input  logic [31:0] crc_error_total_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned payload_count_o,
  output int unsigned marker_count_o,
  output logic [4:0]  status_seen_o
);

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [2:0]  status;
    logic [31:0] total;
  } deframed_beat_t;

  logic             esc_q;
  logic [LenW-1:0]  len_q;
  logic [7:0]       tail_q [TailLen];
  logic [31:0]      crc_q;
  logic [31:0]      mismatch_q;
  deframed_beat_t   deframed_q [$];

  // Bit-serial reflected CRC, one input bit per step.
  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      c = (c[0] ^ b[i]) ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void restart_frame();
    len_q = '0;
    for (int i = 0; i < TailLen; i++) tail_q[i] = 8'h00;
    crc_q = CrcInit;
  endfunction

  // Advance the deframer by one line byte; return 1 when it yields a beat.
  function automatic bit deframe_byte(input logic [7:0] raw, output deframed_beat_t res);
    logic [7:0]  b;
    logic [7:0]  oldest;
    logic [31:0] fcs;
    bit          emit;
    res = '0;
    b = raw;
    if (raw == FlagCode) begin
      emit = 1'b1;
      res.kind = KindEnd;
      if (esc_q) begin
        res.status = StatusAbort;
      end else if (len_q == 0) begin
        emit = 1'b0;
      end else if (len_q <= TailLen) begin
        res.status = StatusShort;
      end else begin
        fcs = {tail_q[3], tail_q[2], tail_q[1], tail_q[0]};
        if ((crc_q ^ CrcInit) == fcs) begin
          res.status = StatusGood;
        end else begin
          res.status = StatusCrcBad;
          mismatch_q = mismatch_q + 32'd1;
        end
      end
      esc_q = 1'b0;
      restart_frame();
      res.total = mismatch_q;
      return emit;
    end
    if (raw == EscCode) begin
      if (esc_q) begin
        // double escape aborts but leaves the escape armed
        restart_frame();
        res.kind   = KindEnd;
        res.status = StatusAbort;
        res.total  = mismatch_q;
        return 1'b1;
      end
      esc_q = 1'b1;
      return 1'b0;
    end
    if (esc_q) b = raw ^ EscFlip;
    esc_q = 1'b0;
    if (int'(len_q) + 1 >= MaxFrame) begin
      // drop the byte; what follows is a new frame
      restart_frame();
      res.kind   = KindEnd;
      res.status = StatusOverrun;
      res.total  = mismatch_q;
      return 1'b1;
    end
    oldest = tail_q[0];
    emit   = len_q >= TailLen;
    for (int i = 0; i < TailLen - 1; i++) tail_q[i] = tail_q[i+1];
    tail_q[TailLen-1] = b;
    len_q = len_q + 1'b1;
    if (emit) begin
      crc_q      = crc_update(crc_q, oldest);
      res.kind   = KindData;
      res.data   = oldest;
      res.total  = mismatch_q;
    end
    return emit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deframed_beat_t want;
    if (!rst_ni) begin
      esc_q      = 1'b0;
      mismatch_q = '0;
      restart_frame();
      deframed_q.delete();
      fail_count_o    = 0;
      payload_count_o = 0;
      marker_count_o  = 0;
      status_seen_o   = '0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (deframe_byte(in_byte_i, want)) deframed_q.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (deframed_q.size() == 0) begin
          $error("unexpected beat: kind %0d byte 0x%02h status %0d total %0d",
                 kind_i, out_byte_i, frame_status_i, crc_error_total_i);
          fail_count_o++;
        end else begin
          want = deframed_q.pop_front();
          if (kind_i !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind_i);
            fail_count_o++;
          end
          if (out_byte_i !== want.data) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, out_byte_i);
            fail_count_o++;
          end
          if (frame_status_i !== want.status) begin
            $error("frame_status: expected %0d, actual %0d", want.status, frame_status_i);
            fail_count_o++;
          end
          if (crc_error_total_i !== want.total) begin
            $error("crc_error_total: expected %0d, actual %0d", want.total,
                   crc_error_total_i);
            fail_count_o++;
          end
          if (want.kind == KindEnd) begin
            marker_count_o++;
            status_seen_o[want.status] = 1'b1;
          end else begin
            payload_count_o++;
          end
        end
      end
    end
    pending_o = deframed_q.size();
  end

endmodule

@@ dv/tb_hdlc_crc32_deframer.sv @@
`timescale 1ns / 1ps
module tb_hdlc_crc32_deframer;
  import hdlc_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  in_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        kind_o;
  logic [7:0]  out_byte_o;
  logic [2:0]  frame_status_o;
  logic [31:0] crc_error_total_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned payload_count;
  int unsigned marker_count;
  logic [4:0]  status_seen;

  int unsigned bytes_sent;
  int unsigned results_taken;
  bit          calm_tx;
  logic [7:0]  frame_q [$];

  hdlc_crc32_deframer i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_byte_i,
    .out_valid_o,
    .out_stall_i,
    .kind_o,
    .out_byte_o,
    .frame_status_o,
    .crc_error_total_o
  );

  hdlc_crc32_deframer_checker i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i        (in_stall_o),
    .in_byte_i,
    .out_valid_i       (out_valid_o),
    .out_stall_i,
    .kind_i            (kind_o),
    .out_byte_i        (out_byte_o),
    .frame_status_i    (frame_status_o),
    .crc_error_total_i (crc_error_total_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .payload_count_o   (payload_count),
    .marker_count_o    (marker_count),
    .status_seen_o     (status_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_line_byte(input logic [7:0] b);
    int unsigned gap;
    gap = calm_tx ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  task automatic send_stuffed(input logic [7:0] b);
    if (b == FlagCode || b == EscCode) begin
      send_line_byte(EscCode);
      send_line_byte(b ^ EscFlip);
    end else begin
      send_line_byte(b);
    end
  endtask

  // Send frame_q stuffed, then its FCS little-endian and a closing flag.
  task automatic send_frame(input bit bad_fcs);
    logic [31:0] crc;
    logic [31:0] fcs;
    crc = CrcInit;
    foreach (frame_q[i]) begin
      crc = crc32_byte(crc, frame_q[i]);
      send_stuffed(frame_q[i]);
    end
    fcs = crc ^ CrcInit;
    if (bad_fcs) fcs[$urandom_range(0, 31)] ^= 1'b1;
    for (int i = 0; i < 4; i++) send_stuffed(fcs[8*i +: 8]);
    send_line_byte(FlagCode);
  endtask

  // Lean toward the codes that need stuffing and the byte extremes.
  function automatic logic [7:0] draw_byte();
    logic [7:0] specials [6];
    specials = '{FlagCode, EscCode, FlagCode ^ EscFlip, EscCode ^ EscFlip, 8'h00, 8'hFF};
    if ($urandom_range(0, 7) == 0) return specials[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic fill_frame(input int unsigned len);
    frame_q.delete();
    repeat (len) frame_q.push_back(draw_byte());
  endtask

  // Receiver: random stall per beat, calm stretches, and a long hold-off now and then.
  initial begin
    int unsigned hold;
    bit          calm_rx;
    out_stall_i   = 1'b0;
    results_taken = 0;
    calm_rx       = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (results_taken % 64 == 0) calm_rx = ($urandom_range(0, 3) == 0);
      hold = calm_rx ? 0 : $urandom_range(0, 11);
      if (results_taken % 700 == 200) hold = 250;
      repeat (hold) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      results_taken++;
    end
  end

  initial begin
    int unsigned random_start;
    int unsigned n;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_byte_i  = 8'h00;
    calm_tx    = 1'b0;
    bytes_sent = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // idle flags, short frames at both lengths
    send_line_byte(FlagCode);
    send_line_byte(FlagCode);
    send_line_byte(8'h00);
    send_line_byte(FlagCode);
    send_line_byte(8'hFF);
    send_line_byte(8'h01);
    send_line_byte(8'h80);
    send_line_byte(8'h7F);
    send_line_byte(FlagCode);
    // good and corrupted frames carrying the stuffed codes
    frame_q = '{8'h00, 8'hFF, FlagCode, EscCode, 8'h55};
    send_frame(1'b0);
    send_frame(1'b1);
    // escape then flag; double escape, after which the next byte is unstuffed
    send_line_byte(EscCode);
    send_line_byte(FlagCode);
    send_line_byte(EscCode);
    send_line_byte(EscCode);
    send_line_byte(8'h5E);
    send_line_byte(EscCode);
    send_line_byte(8'h41);
    send_line_byte(FlagCode);

    // overflow: fill to the limit, then a frame with no opening flag
    for (int i = 0; i < MaxFrame; i++) send_line_byte(8'($urandom_range(0, 120)));
    fill_frame(6);
    send_frame(1'b0);

    random_start = bytes_sent;
    while (bytes_sent < random_start + 500) begin
      case ($urandom_range(0, 9))
        7: begin
          // noise heavy in flags and escapes
          n = $urandom_range(1, 8);
          repeat (n) begin
            case ($urandom_range(0, 2))
              0:       send_line_byte(FlagCode);
              1:       send_line_byte(EscCode);
              default: send_line_byte(8'($urandom_range(0, 255)));
            endcase
          end
        end
        8: begin
          // frame cut by an abort
          fill_frame($urandom_range(0, 6));
          foreach (frame_q[i]) send_stuffed(frame_q[i]);
          send_line_byte(EscCode);
          send_line_byte($urandom_range(0, 1) ? FlagCode : EscCode);
        end
        9: calm_tx = ($urandom_range(0, 2) == 0);
        default: begin
          fill_frame(($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                 : $urandom_range(0, 12));
          send_frame($urandom_range(0, 5) == 0);
        end
      endcase
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d line bytes; checked %0d payload bytes and %0d end markers.",
             bytes_sent, payload_count, marker_count);
    $display("End marker status codes seen (bit per code, overflow down to good): %b",
             status_seen);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
